// ----- sv/mtpe_pkg.sv -----
`timescale 1ns / 1ps
// Package for the memory test pattern engine: sizes, codes and shared types.
// Used by mtpe_seq, memory_test_pattern_engine_core, mtpe_checker and tb.
package mtpe_pkg;

    localparam int DATA_BUS_BITS    = 32;
    localparam int MAX_REGION_LOG2  = 26;
    localparam int MIN_REGION_LOG2  = 3;
    localparam int INTEGRITY_STRIDE = 15;
    // index counters hold offsets up to twice the largest region
    localparam int IDX_W = MAX_REGION_LOG2 + 2;

    localparam logic [31:0] PAT_A = 32'hAAAA_AAAA;
    localparam logic [31:0] PAT_5 = 32'h5555_5555;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_PASS  = 2'd2;
    localparam logic [1:0] KIND_FAIL  = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_RESP  = 1'b1;

    localparam logic [1:0] TEST_WALK   = 2'd0;
    localparam logic [1:0] TEST_ADDR   = 2'd1;
    localparam logic [1:0] TEST_ENERGY = 2'd2;
    localparam logic [1:0] TEST_INTEG  = 2'd3;

    localparam logic [1:0] REG_TEST_SELECT = 2'd0;
    localparam logic [1:0] REG_BASE        = 2'd1;
    localparam logic [1:0] REG_LOG2        = 2'd2;
    localparam logic [1:0] REG_SEED        = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_WRITE  = 3'b010,
        PH_VERIFY = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [IDX_W-1:0] outer;
        logic [IDX_W-1:0] inner;
        logic [3:0]       pass_num;
        logic [3:0]       stride;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  test;
        logic [31:0] base;
        logic [4:0]  log2;
        logic [6:0]  seed;
    } run_cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic [31:0] data;   // write data, or expected value of a read
        logic        word;
    } req_t;

endpackage

// ----- sv/mtpe_seq.sv -----
`timescale 1ns / 1ps
// Next-request logic: from the test position and run configuration, the next
// memory request or pass report and the advanced position. Uses mtpe_pkg.
module mtpe_seq import mtpe_pkg::*; (
    input  seq_state_t st,
    input  run_cfg_t   cfg,
    output seq_state_t nxt,
    output req_t       req
);

    logic [IDX_W-1:0] mem;
    logic [IDX_W-1:0] count_e;
    logic [IDX_W-1:0] words;
    logic [IDX_W-1:0] j2;
    logic [IDX_W-1:0] o2;
    logic [4:0]       p1;
    logic [31:0]      n32;

    function automatic logic [IDX_W-1:0] npow(input logic [IDX_W-1:0] x);
        npow = (x == '0) ? IDX_W'(1) : (x << 1);
    endfunction

    function automatic logic [31:0] woff(input logic [IDX_W-1:0] x);
        woff = 32'(x) << 2;
    endfunction

    always_comb begin
        mem     = IDX_W'(1) << cfg.log2;
        count_e = mem >> 3;
        words   = mem >> 2;
        j2      = npow(st.inner);
        o2      = npow(st.outer);
        p1      = {1'b0, st.pass_num} + 5'd1;
        n32     = 32'(st.inner) + 32'd1;
        nxt     = st;
        req     = '{kind: KIND_PASS, address: 32'd0, data: 32'd0, word: 1'b0};

        case (cfg.test)
            TEST_WALK: begin
                if (st.inner < IDX_W'(DATA_BUS_BITS)) begin
                    req = '{kind: (st.phase == PH_WRITE) ? KIND_WRITE : KIND_READ,
                            address: cfg.base + woff(st.inner),
                            data: 32'd1 << st.inner[4:0], word: 1'b1};
                    nxt.inner = st.inner + IDX_W'(1);
                end else if (st.phase == PH_WRITE) begin
                    nxt.phase = PH_VERIFY;
                    nxt.inner = IDX_W'(1);
                    req = '{kind: KIND_READ, address: cfg.base, data: 32'd1, word: 1'b1};
                end else begin
                    nxt.phase = PH_IDLE;
                end
            end
            TEST_ADDR: begin
                if (st.phase == PH_WRITE) begin
                    if (st.inner < mem) begin
                        req = '{kind: KIND_WRITE, address: cfg.base + 32'(st.inner),
                                data: 32'(cfg.seed), word: 1'b0};
                        nxt.inner = j2;
                    end else begin
                        // invert the byte at the offset under test
                        nxt.phase = PH_VERIFY;
                        nxt.inner = '0;
                        req = '{kind: KIND_WRITE, address: cfg.base + 32'(st.outer),
                                data: {24'd0, ~{1'b0, cfg.seed}}, word: 1'b0};
                    end
                end else if (st.inner < mem && st.inner != st.outer) begin
                    req = '{kind: KIND_READ, address: cfg.base + 32'(st.inner),
                            data: 32'(cfg.seed), word: 1'b0};
                    nxt.inner = j2;
                end else if (st.inner < mem && j2 < mem) begin
                    // skip the inverted offset
                    req = '{kind: KIND_READ, address: cfg.base + 32'(j2),
                            data: 32'(cfg.seed), word: 1'b0};
                    nxt.inner = npow(j2);
                end else begin
                    nxt.outer = o2;
                    if (o2 < mem) begin
                        nxt.phase = PH_WRITE;
                        nxt.inner = IDX_W'(1);
                        req = '{kind: KIND_WRITE, address: cfg.base,
                                data: 32'(cfg.seed), word: 1'b0};
                    end else begin
                        nxt.phase = PH_IDLE;
                    end
                end
            end
            TEST_ENERGY: begin
                if (st.inner < count_e) begin
                    req.kind = (st.phase == PH_WRITE) ? KIND_WRITE : KIND_READ;
                    req.word = 1'b1;
                    if (st.stride == 4'd0) begin
                        req.address = cfg.base + woff(st.inner);
                        req.data    = n32;
                        nxt.stride  = 4'd1;
                    end else begin
                        req.address = cfg.base + 32'(mem) - 32'd4 - woff(st.inner);
                        req.data    = ~n32;
                        nxt.stride  = 4'd0;
                        nxt.inner   = st.inner + IDX_W'(1);
                    end
                end else if (st.phase == PH_WRITE) begin
                    nxt.phase  = PH_VERIFY;
                    nxt.inner  = '0;
                    nxt.stride = 4'd1;
                    req = '{kind: KIND_READ, address: cfg.base, data: 32'd1, word: 1'b1};
                end else begin
                    nxt.phase = PH_IDLE;
                end
            end
            default: begin
                if (st.phase == PH_WRITE) begin
                    if (st.inner < words) begin
                        req = '{kind: KIND_WRITE, address: cfg.base + woff(st.inner),
                                data: (st.stride == 4'd0) ? PAT_A : PAT_5, word: 1'b1};
                        nxt.inner  = st.inner + IDX_W'(1);
                        nxt.stride = (5'(st.stride) + 5'd1 >= 5'(INTEGRITY_STRIDE)) ?
                                     4'd0 : st.stride + 4'd1;
                    end else begin
                        nxt.phase = PH_VERIFY;
                        nxt.inner = IDX_W'(st.pass_num) + IDX_W'(INTEGRITY_STRIDE);
                        req = '{kind: KIND_READ,
                                address: cfg.base + woff(IDX_W'(st.pass_num)),
                                data: PAT_A, word: 1'b1};
                    end
                end else if (st.inner < words) begin
                    req = '{kind: KIND_READ, address: cfg.base + woff(st.inner),
                            data: PAT_A, word: 1'b1};
                    nxt.inner = st.inner + IDX_W'(INTEGRITY_STRIDE);
                end else begin
                    nxt.pass_num = p1[3:0];
                    // passes past the top word are empty, so the run ends there
                    if (p1 < 5'(INTEGRITY_STRIDE) && IDX_W'(p1) < words) begin
                        nxt.phase  = PH_WRITE;
                        nxt.inner  = IDX_W'(p1) + IDX_W'(1);
                        nxt.stride = 4'd1;
                        req = '{kind: KIND_WRITE, address: cfg.base + woff(IDX_W'(p1)),
                                data: PAT_A, word: 1'b1};
                    end else begin
                        nxt.phase = PH_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

// ----- sv/memory_test_pattern_engine_core.sv -----
`timescale 1ns / 1ps
// Memory test pattern engine top level: handshake, configuration, run state,
// read-back check and output register. Uses mtpe_pkg and mtpe_seq.
// Each accepted item's result is registered in the output register in the next cycle.
// Throughput: one item per cycle; each response yields the next request from
// counters in a single pass, and the output register frees s_tready while m_tready is high.
// Reset (aresetn low, synchronous) idles the run and restores the registers.
module memory_test_pattern_engine_core import mtpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] read_data
    input  logic         s_tuser,   // [0] op
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] address, [63:32] write_data, [64] word_access, [96:65] expected,
    // [128:97] found, [135:129] zero
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    output logic         m_tlast
);

    logic [1:0]  test_sel_reg;
    logic [31:0] base_reg;
    logic [4:0]  log2_reg;
    logic [6:0]  seed_reg;
    run_cfg_t    run_reg, run_next;
    seq_state_t  st_reg, st_next, seq_in, seq_out;
    req_t        req;
    logic        pend_reg, pend_next;
    logic        pend_word_reg, pend_word_next;
    logic [31:0] pend_addr_reg, pend_addr_next;
    logic [31:0] pend_exp_reg, pend_exp_next;
    logic        out_valid_reg, out_valid_next;
    logic [135:0] out_data_reg, out_data_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic        accept, start;
    logic [31:0] found;
    logic [4:0]  sat_log2;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign start    = (s_tuser == OP_START);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = (out_kind_reg == KIND_PASS) || (out_kind_reg == KIND_FAIL);

    always_comb begin
        sat_log2 = log2_reg;
        if (log2_reg < 5'(MIN_REGION_LOG2)) sat_log2 = 5'(MIN_REGION_LOG2);
        if (log2_reg > 5'(MAX_REGION_LOG2)) sat_log2 = 5'(MAX_REGION_LOG2);
    end

    always_comb begin
        run_next = run_reg;
        seq_in   = st_reg;
        if (start) begin
            run_next = '{test: test_sel_reg, base: base_reg, log2: sat_log2, seed: seed_reg};
            seq_in   = '{phase: PH_WRITE, outer: '0, inner: '0, pass_num: 4'd0, stride: 4'd0};
        end
    end

    mtpe_seq u_seq (
        .st  (seq_in),
        .cfg (run_next),
        .nxt (seq_out),
        .req (req)
    );

    assign found = pend_word_reg ? s_tdata : {24'd0, s_tdata[7:0]};

    always_comb begin
        st_next        = st_reg;
        pend_next      = pend_reg;
        pend_word_next = pend_word_reg;
        pend_addr_next = pend_addr_reg;
        pend_exp_next  = pend_exp_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        if (accept && (start || st_reg.phase != PH_IDLE)) begin
            out_valid_next = 1'b1;
            if (!start && pend_reg && found != pend_exp_reg) begin
                // first mismatch ends the run
                st_next       = st_reg;
                st_next.phase = PH_IDLE;
                pend_next     = 1'b0;
                out_kind_next = KIND_FAIL;
                out_data_next = {7'd0, found, pend_exp_reg, pend_word_reg, 32'd0,
                                 pend_addr_reg};
            end else begin
                st_next        = seq_out;
                out_kind_next  = req.kind;
                pend_next      = (req.kind == KIND_READ);
                pend_word_next = req.word;
                pend_addr_next = req.address;
                pend_exp_next  = req.data;
                case (req.kind)
                    KIND_WRITE: out_data_next = {7'd0, 32'd0, 32'd0, req.word, req.data,
                                                 req.address};
                    KIND_READ:  out_data_next = {7'd0, 32'd0, 32'd0, req.word, 32'd0,
                                                 req.address};
                    default:    out_data_next = '0;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            test_sel_reg  <= TEST_WALK;
            base_reg      <= 32'd0;
            log2_reg      <= 5'(MAX_REGION_LOG2);
            seed_reg      <= 7'd0;
            run_reg       <= '{test: TEST_WALK, base: 32'd0, log2: 5'(MIN_REGION_LOG2),
                               seed: 7'd0};
            st_reg        <= '{phase: PH_IDLE, outer: '0, inner: '0, pass_num: 4'd0,
                               stride: 4'd0};
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEST_SELECT: test_sel_reg <= cfg_wdata[1:0];
                    REG_BASE:        base_reg     <= cfg_wdata;
                    REG_LOG2:        log2_reg     <= cfg_wdata[4:0];
                    REG_SEED:        seed_reg     <= cfg_wdata[6:0];
                    default:         ;
                endcase
            end
            if (accept) run_reg <= run_next;
            st_reg        <= st_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_word_reg <= pend_word_next;
        pend_addr_reg <= pend_addr_next;
        pend_exp_reg  <= pend_exp_next;
        out_data_reg  <= out_data_next;
        out_kind_reg  <= out_kind_next;
    end

`ifndef SYNTHESIS
    // a response while idle produces nothing
    a_idle_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser == OP_RESP && st_reg.phase == PH_IDLE |=> !m_tvalid)
        else $error("result produced for response while idle");

    // a final report leaves the run idle with no check pending
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && out_valid_next && (out_kind_next == KIND_PASS ||
        out_kind_next == KIND_FAIL) |=> st_reg.phase == PH_IDLE && !pend_reg)
        else $error("run not idle after final report");

    // a check is pending after every read request
    a_pend_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && out_valid_next && out_kind_next == KIND_READ |=> pend_reg)
        else $error("read issued without pending check");
`endif

endmodule

// ----- dv/mtpe_checker.sv -----
`timescale 1ns / 1ps
// Checker for memory_test_pattern_engine_core: watches the config port and both
// stream channels, predicts each result and compares it. Uses mtpe_pkg.
module mtpe_checker import mtpe_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending
);

    typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_INVERT, ST_VERIFY} step_t;
    typedef enum logic [1:0] {CK_NONE, CK_WORD, CK_BYTE} chk_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic        word;
        logic [31:0] expv;
        logic [31:0] fnd;
        logic        last;
    } beat_t;

    beat_t req_q[$];

    // registers as written, and the copy latched at start
    logic [1:0]  c_test, r_test;
    logic [31:0] c_base, r_base;
    logic [4:0]  c_log2, r_log2;
    logic [6:0]  c_seed, r_seed;

    step_t       st;
    logic [31:0] outer, inner;
    int          pass_no;
    logic [3:0]  stride;
    chk_t        ck;
    logic [31:0] ck_addr, ck_val;

    function automatic beat_t mk(logic [1:0] k, logic [31:0] a, logic [31:0] d, logic w,
                                 logic [31:0] e, logic [31:0] f, logic l);
        beat_t b;
        b.kind = k; b.addr = a; b.wdata = d; b.word = w; b.expv = e; b.fnd = f; b.last = l;
        return b;
    endfunction

    function automatic beat_t wr_req(logic [31:0] a, logic [31:0] d, logic w);
        ck = CK_NONE;
        return mk(KIND_WRITE, a, d, w, 32'd0, 32'd0, 1'b0);
    endfunction

    function automatic beat_t rd_req(logic [31:0] a, logic [31:0] e, logic w);
        ck = w ? CK_WORD : CK_BYTE;
        ck_addr = a;
        ck_val = e;
        return mk(KIND_READ, a, 32'd0, w, 32'd0, 32'd0, 1'b0);
    endfunction

    function automatic beat_t run_pass();
        st = ST_IDLE;
        ck = CK_NONE;
        return mk(KIND_PASS, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1);
    endfunction

    function automatic logic [31:0] next_pow(logic [31:0] x);
        return (x == 32'd0) ? 32'd1 : (x << 1);
    endfunction

    // Request at the current position; advances the counters.
    function automatic beat_t next_req();
        logic [31:0] msz, i, j, n, a, d;
        msz = 32'd1 << r_log2;
        forever begin
            case (r_test)
                TEST_WALK: begin
                    if (inner < DATA_BUS_BITS) begin
                        a = r_base + 32'd4 * inner;
                        d = 32'd1 << inner;
                        inner++;
                        if (st == ST_WRITE) return wr_req(a, d, 1'b1);
                        return rd_req(a, d, 1'b1);
                    end
                    if (st == ST_WRITE) begin
                        st = ST_VERIFY;
                        inner = '0;
                    end else return run_pass();
                end
                TEST_ADDR: begin
                    i = outer;
                    j = inner;
                    if (st == ST_WRITE) begin
                        if (j < msz) begin
                            inner = next_pow(j);
                            return wr_req(r_base + j, {25'd0, r_seed}, 1'b0);
                        end
                        st = ST_INVERT;
                    end else if (st == ST_INVERT) begin
                        st = ST_VERIFY;
                        inner = '0;
                        return wr_req(r_base + i, {24'd0, ~{1'b0, r_seed}}, 1'b0);
                    end else if (j < msz) begin
                        inner = next_pow(j);
                        if (j != i) return rd_req(r_base + j, {25'd0, r_seed}, 1'b0);
                    end else begin
                        outer = next_pow(i);
                        if (outer < msz) begin
                            st = ST_WRITE;
                            inner = '0;
                        end else return run_pass();
                    end
                end
                TEST_ENERGY: begin
                    i = inner;
                    n = i + 32'd1;
                    if (i < (msz >> 3)) begin
                        if (stride == 4'd0) begin
                            a = r_base + 32'd4 * i;
                            d = n;
                            stride = 4'd1;
                        end else begin
                            a = r_base + msz - 32'd4 - 32'd4 * i;
                            d = ~n;
                            stride = 4'd0;
                            inner++;
                        end
                        if (st == ST_WRITE) return wr_req(a, d, 1'b1);
                        return rd_req(a, d, 1'b1);
                    end
                    if (st == ST_WRITE) begin
                        st = ST_VERIFY;
                        inner = '0;
                        stride = 4'd0;
                    end else return run_pass();
                end
                default: begin
                    j = inner;
                    if (st == ST_WRITE) begin
                        if (j < (msz >> 2)) begin
                            d = (stride == 4'd0) ? PAT_A : PAT_5;
                            inner++;
                            stride = (stride + 1 >= INTEGRITY_STRIDE) ? 4'd0 : stride + 4'd1;
                            return wr_req(r_base + 32'd4 * j, d, 1'b1);
                        end
                        st = ST_VERIFY;
                        inner = 32'(pass_no);
                    end else if (j < (msz >> 2)) begin
                        inner = j + 32'(INTEGRITY_STRIDE);
                        return rd_req(r_base + 32'd4 * j, PAT_A, 1'b1);
                    end else begin
                        pass_no++;
                        if (pass_no < INTEGRITY_STRIDE) begin
                            st = ST_WRITE;
                            inner = 32'(pass_no);
                            stride = 4'd0;
                        end else return run_pass();
                    end
                end
            endcase
        end
        return run_pass();
    endfunction

    task automatic cmp_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        beat_t e;
        logic [31:0] f;
        if (!aresetn) begin
            c_test = '0; c_base = '0; c_log2 = 5'd26; c_seed = '0;
            r_test = '0; r_base = '0; r_log2 = 5'd3; r_seed = '0;
            st = ST_IDLE; outer = '0; inner = '0; pass_no = 0; stride = 4'd0;
            ck = CK_NONE; ck_addr = '0; ck_val = '0;
            req_q.delete();
            fail_count = 0;
        end else begin
            // compare first: a transfer's result leaves no earlier than the next edge
            if (m_tvalid && m_tready) begin
                if (req_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d addr %h",
                             $time, m_tuser, m_tdata[31:0]);
                    fail_count++;
                end else begin
                    e = req_q.pop_front();
                    cmp_field("kind", 32'(e.kind), 32'(m_tuser));
                    cmp_field("address", e.addr, m_tdata[31:0]);
                    cmp_field("write_data", e.wdata, m_tdata[63:32]);
                    cmp_field("word_access", 32'(e.word), 32'(m_tdata[64]));
                    cmp_field("expected", e.expv, m_tdata[96:65]);
                    cmp_field("found", e.fnd, m_tdata[128:97]);
                    cmp_field("last", 32'(e.last), 32'(m_tlast));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEST_SELECT: c_test = cfg_wdata[1:0];
                    REG_BASE:        c_base = cfg_wdata;
                    REG_LOG2:        c_log2 = cfg_wdata[4:0];
                    default:         c_seed = cfg_wdata[6:0];
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_START) begin
                    r_test = c_test;
                    r_base = c_base;
                    r_log2 = (c_log2 < MIN_REGION_LOG2) ? 5'(MIN_REGION_LOG2) :
                             (c_log2 > MAX_REGION_LOG2) ? 5'(MAX_REGION_LOG2) : c_log2;
                    r_seed = c_seed;
                    st = ST_WRITE; outer = '0; inner = '0; pass_no = 0; stride = 4'd0;
                    ck = CK_NONE; ck_addr = '0; ck_val = '0;
                    req_q.push_back(next_req());
                end else if (st != ST_IDLE) begin
                    if (ck != CK_NONE) begin
                        f = (ck == CK_WORD) ? s_tdata : {24'd0, s_tdata[7:0]};
                        if (f != ck_val) begin
                            st = ST_IDLE;
                            req_q.push_back(mk(KIND_FAIL, ck_addr, 32'd0, ck == CK_WORD,
                                               ck_val, f, 1'b1));
                            ck = CK_NONE;
                        end else begin
                            ck = CK_NONE;
                            req_q.push_back(next_req());
                        end
                    end else req_q.push_back(next_req());
                end
            end
        end
        pending = req_q.size();
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for memory_test_pattern_engine_core: memory model answering the
// requests, configuration, idling and verdict. Uses mtpe_pkg and mtpe_checker.
module tb;
    import mtpe_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    int fail_count, pending;
    int idle_pct = 0, stall_pct = 0;
    int items = 0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic        word;
    } mem_req_t;

    mem_req_t      mem_reqs[$];
    logic [7:0]    mem_bytes[bit [31:0]];

    memory_test_pattern_engine_core uut (.*);

    mtpe_checker chk (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= stall_pct);
        if (aresetn && m_tvalid && m_tready)
            mem_reqs.push_back({m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[64]});
    end

    task automatic send_item(logic op, logic [31:0] d);
        if ($urandom_range(99, 0) < idle_pct)
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        items++;
    endtask

    task automatic write_regs(logic [1:0] test, logic [31:0] base, logic [4:0] log2,
                              logic [6:0] seed);
        // let the block settle after the last transfer
        repeat (3) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TEST_SELECT; cfg_wdata <= 32'(test);
        @(posedge aclk);
        cfg_index <= REG_BASE; cfg_wdata <= base;
        @(posedge aclk);
        cfg_index <= REG_LOG2; cfg_wdata <= 32'(log2);
        @(posedge aclk);
        cfg_index <= REG_SEED; cfg_wdata <= 32'(seed);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] mem_load(logic [31:0] a, logic word);
        logic [31:0] v;
        v = $urandom;
        for (int k = 0; k < (word ? 4 : 1); k++)
            if (mem_bytes.exists(a + k)) v[8*k +: 8] = mem_bytes[a + k];
        return v;
    endfunction

    // Start the configured test and answer each request (or, at random, restart the run) until it reports done.
    task automatic run_test(int restart_odds, int fault_odds);
        mem_req_t r;
        logic [31:0] d;
        send_item(OP_START, $urandom);
        forever begin
            while (mem_reqs.size() == 0) @(posedge aclk);
            r = mem_reqs.pop_front();
            if (r.kind == KIND_PASS || r.kind == KIND_FAIL) break;
            if ($urandom_range(restart_odds, 0) == 0) begin
                send_item(OP_START, $urandom);
            end else if (r.kind == KIND_WRITE) begin
                for (int k = 0; k < (r.word ? 4 : 1); k++)
                    mem_bytes[r.addr + k] = r.wdata[8*k +: 8];
                send_item(OP_RESP, $urandom);
            end else begin
                d = mem_load(r.addr, r.word);
                if ($urandom_range(fault_odds, 0) == 0)
                    d[r.word ? $urandom_range(31, 0) : $urandom_range(7, 0)] ^= 1'b1;
                send_item(OP_RESP, d);
            end
        end
        // responses to an idle block are dropped
        if ($urandom_range(3, 0) == 0) send_item(OP_RESP, $urandom);
    endtask

    initial begin
        logic [1:0] test;
        logic [4:0] log2;
        logic [31:0] base;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle responses, smallest runs, extremes of registers
        send_item(OP_RESP, 32'hFFFF_FFFF);
        @(posedge aclk);
        send_item(OP_RESP, 32'h0000_0000);
        write_regs(TEST_ENERGY, 32'h0, 5'd0, 7'd0);
        run_test(100000, 100000);
        write_regs(TEST_INTEG, 32'hFFFF_FFFC, 5'd3, 7'd127);
        run_test(100000, 100000);
        write_regs(TEST_ADDR, 32'h0000_1003, 5'd31, 7'd99);
        run_test(100000, 2);
        write_regs(TEST_WALK, 32'hFFFF_FFFF, 5'd31, 7'd100);
        run_test(100000, 20);

        while (items < 2000) begin
            idle_pct  = (items >= 500 && items < 1000) ? 69 : (items >= 1500) ? 36 : 0;
            stall_pct = (items >= 1000 && items < 1500) ? 69 : (items >= 1500) ? 36 : 0;
            test = 2'($urandom_range(3, 0));
            base = ($urandom_range(3, 0) == 0) ? $urandom : ($urandom_range(1023, 0) << 2);
            case (test)
                TEST_WALK:   log2 = 5'($urandom_range(31, 0));
                TEST_ADDR:   log2 = $urandom_range(4, 0) == 0 ? 5'($urandom_range(31, 0))
                                                             : 5'($urandom_range(8, 0));
                default:     log2 = 5'($urandom_range(7, 0));
            endcase
            write_regs(test, base, log2, 7'($urandom_range(127, 0)));
            run_test(300, 120);
        end

        while (pending != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
